FILE: src/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg
// Shared types and codes for the sorted priority job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sjq_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 16;
  localparam int OCC_W  = 7;
  localparam int STAT_W = 2;
  localparam int OUT_W  = 40;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_POP    = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [ID_W-1:0]          id_t;
  typedef logic signed [PRIO_W-1:0] prio_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic  ins_en;
    logic  pop_en;
    id_t   new_id;
    prio_t new_prio;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/sjq_cell.sv
// ----------------------------------------------------------------------------
// sjq_cell
// One slot of the sorted chain: keeps, loads the new job, or takes a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module sjq_cell (
  input  wire logic               clk,
  input  wire sjq_pkg::cell_ctrl_t ctrl,
  input  wire logic               occupied,
  input  wire logic               left_ge,
  input  wire sjq_pkg::id_t       left_id,
  input  wire sjq_pkg::prio_t     left_prio,
  input  wire sjq_pkg::id_t       right_id,
  input  wire sjq_pkg::prio_t     right_prio,
  output logic                    ge,
  output sjq_pkg::id_t            id,
  output sjq_pkg::prio_t          prio
);
  import sjq_pkg::*;

  assign ge = occupied && (prio >= ctrl.new_prio);

  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !ge) begin
      if (left_ge) begin
        id   <= ctrl.new_id;
        prio <= ctrl.new_prio;
      end else begin
        id   <= left_id;
        prio <= left_prio;
      end
    end else if (ctrl.pop_en) begin
      id   <= right_id;
      prio <= right_prio;
    end
  end

endmodule

`default_nettype wire

FILE: src/sorted_priority_job_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_job_queue
// Bounded priority queue of jobs held sorted in a chain of cells, head first.
// ----------------------------------------------------------------------------
//  channel  dir  tuser            tdata
//  s_axis   in   action           priority_req
//  m_axis   out  status           job_id, job_priority, occupancy
//
//  One transfer in per cycle unless the output stalls, one registered
//  result per transfer in the cycle after it. Every cell compares against
//  the new priority in parallel and shifts left or right in the same cycle.
//  Reset clears the count and sets the next id to one; entries need no clear.
//  A stalled result holds in the output register; input stalls with it.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_job_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [15:0]               s_axis_tdata,   // [15:0] priority_req
  input  wire logic                      s_axis_tuser,   // [0] action
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [sjq_pkg::OUT_W-1:0]      m_axis_tdata,   // [15:0] job_id,
                                                         // [31:16] job_priority,
                                                         // [38:32] occupancy
  output logic [sjq_pkg::STAT_W-1:0]     m_axis_tuser    // [1:0] status
);
  import sjq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] count;
  id_t              next_id;

  id_t   cell_id   [QUEUE_DEPTH];
  prio_t cell_prio [QUEUE_DEPTH];
  logic  cell_ge   [QUEUE_DEPTH];

  logic       accept, is_ins, full, empty;
  cell_ctrl_t ctrl;
  prio_t      req_prio;

  status_t out_status;
  id_t     out_id;
  prio_t   out_prio;
  logic [OCC_W-1:0] out_occ;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_ins   = (s_axis_tuser == ACT_INSERT);
  assign req_prio = s_axis_tdata;
  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.ins_en   = accept && is_ins && !full;
  assign ctrl.pop_en   = accept && !is_ins && !empty;
  assign ctrl.new_id   = next_id;
  assign ctrl.new_prio = req_prio;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   l_ge;
    id_t    l_id, r_id;
    prio_t  l_prio, r_prio;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign l_ge   = 1'b1;
      assign l_id   = next_id;
      assign l_prio = req_prio;
    end else begin : g_body
      assign l_ge   = cell_ge[i-1];
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id   = cell_id[i];
      assign r_prio = cell_prio[i];
    end else begin : g_mid
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    sjq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .left_ge    (l_ge),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_prio (r_prio),
      .ge         (cell_ge[i]),
      .id         (cell_id[i]),
      .prio       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      next_id       <= ID_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (ctrl.ins_en) begin
        count   <= count + CNT_W'(1);
        next_id <= next_id + ID_W'(1);
      end else if (ctrl.pop_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_ins) begin
        if (full) begin
          out_status <= ST_FULL;
          out_id     <= '0;
          out_prio   <= '0;
          out_occ    <= OCC_W'(count);
        end else begin
          out_status <= ST_OK;
          out_id     <= next_id;
          out_prio   <= req_prio;
          out_occ    <= OCC_W'(count + CNT_W'(1));
        end
      end else begin
        if (empty) begin
          out_status <= ST_EMPTY;
          out_id     <= '0;
          out_prio   <= '0;
          out_occ    <= OCC_W'(count);
        end else begin
          out_status <= ST_OK;
          out_id     <= cell_id[0];
          out_prio   <= cell_prio[0];
          out_occ    <= OCC_W'(count - CNT_W'(1));
        end
      end
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {1'b0, out_occ, out_prio, out_id};

endmodule

`default_nettype wire

FILE: sim/sorted_priority_job_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_job_queue_tb
// Self-checking bench for the sorted priority job queue. A tracker class keeps
// its own sorted job list and id counter, predicts one result per accepted
// transfer and compares each result field by field. Directed jobs cover
// the priority extremes, ties and empty pops. Random phases then fill, drain
// and mix the queue with random gaps on both sides.
// ----------------------------------------------------------------------------

module sorted_priority_job_queue_tb;
  import sjq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct {
    status_t    status;
    id_t        id;
    prio_t      prio;
    logic [6:0] occ;
  } job_result_t;

  class job_order_tracker;
    int          depth;
    id_t         next_id;
    id_t         held_id[$];
    prio_t       held_prio[$];
    job_result_t awaited[$];
    int          errors;

    function new(int d);
      depth   = d;
      next_id = 1;
      errors  = 0;
    endfunction

    function void note_job(logic act, prio_t prio_req);
      job_result_t r;
      int          pos;
      r.status = ST_OK;
      r.id     = '0;
      r.prio   = '0;
      if (act == ACT_INSERT) begin
        if (held_id.size() >= depth) begin
          r.status = ST_FULL;
        end else begin
          r.id    = next_id;
          r.prio  = prio_req;
          next_id = next_id + 1'b1;
          pos     = held_id.size();
          // go behind every job of equal or higher priority
          while (pos > 0 && held_prio[pos-1] < prio_req) pos--;
          held_id.insert(pos, r.id);
          held_prio.insert(pos, prio_req);
        end
      end else begin
        if (held_id.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id   = held_id.pop_front();
          r.prio = held_prio.pop_front();
        end
      end
      r.occ = 7'(held_id.size());
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] status, id_t id, prio_t prio, logic [6:0] occ);
      job_result_t r;
      if (awaited.size() == 0) begin
        report_mismatch("result with no job awaiting it");
      end else begin
        r = awaited.pop_front();
        if (status !== r.status)
          report_mismatch($sformatf("status exp %0d got %0d", r.status, status));
        if (id !== r.id)
          report_mismatch($sformatf("job_id exp %0d got %0d", r.id, id));
        if (prio !== r.prio)
          report_mismatch($sformatf("job_priority exp %0d got %0d", r.prio, prio));
        if (occ !== r.occ)
          report_mismatch($sformatf("occupancy exp %0d got %0d", r.occ, occ));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;   // [15:0] job_id, [31:16] job_priority,
                                     // [38:32] occupancy
  logic [STAT_W-1:0] m_axis_tuser;   // [1:0] status

  bit               burst;
  int               idle_cycles;
  job_order_tracker tracker;

  sorted_priority_job_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_draw();
    if (burst) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic prio_t rand_prio();
    case ($urandom_range(0, 3))
      0: return prio_t'($urandom_range(0, 6)) - prio_t'(3);
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd32767;
          default: return 16'sd32766;
        endcase
      end
      default: return prio_t'($urandom());
    endcase
  endfunction

  task send_job(logic act, prio_t prio);
    int gap;
    gap = idle_draw();
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = prio;
    s_axis_tuser  = act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // predict on each input transfer, then check each output transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_job(s_axis_tuser, prio_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(m_axis_tuser, m_axis_tdata[15:0],
                             prio_t'(m_axis_tdata[31:16]), m_axis_tdata[38:32]);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_priority_job_queue regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall a random number of cycles before each transfer
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = idle_draw();
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int mode;
    int ins_pct;
    tracker       = new(QUEUE_DEPTH);
    idle_cycles   = 0;
    burst         = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_INSERT;
    rst           = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty pop, extremes, ties, then drain past empty
    send_job(ACT_POP, 16'sh7fff);
    send_job(ACT_INSERT, 16'sh7fff);
    send_job(ACT_INSERT, -16'sd32768);
    send_job(ACT_INSERT, 16'sd0);
    send_job(ACT_INSERT, 16'sd0);
    send_job(ACT_INSERT, -16'sd1);
    send_job(ACT_INSERT, 16'sd1);
    send_job(ACT_INSERT, 16'sh7fff);
    send_job(ACT_INSERT, -16'sd32768);
    repeat (4) begin
      send_job(ACT_POP, 16'sh0000);
      send_job(ACT_POP, -16'sd1);
    end
    send_job(ACT_POP, 16'sh5555);
    send_job(ACT_INSERT, 16'sd5);
    send_job(ACT_POP, 16'sh2aaa);
    send_job(ACT_POP, 16'sh0000);

    for (int phase = 0; phase < 17; phase++) begin
      mode  = (phase == 0) ? 0 : $urandom_range(0, 2);
      burst = ($urandom_range(0, 3) == 0);
      case (mode)
        0:       ins_pct = 95;
        1:       ins_pct = 10;
        default: ins_pct = 50;
      endcase
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(1, 100) <= ins_pct) send_job(ACT_INSERT, rand_prio());
        else send_job(ACT_POP, prio_t'($urandom()));
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    burst         = 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("sorted_priority_job_queue regression: pass");
    end else begin
      $display("sorted_priority_job_queue regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sjq_pkg.sv
src/sjq_cell.sv
src/sorted_priority_job_queue.sv
sim/sorted_priority_job_queue_tb.sv
